// ===== rtl/packet_deframer_checksum15_macros.svh =====
// Assertion macros shared by the deframer RTL.
// Each expects signals named clk and rst_n in the using scope.
`ifndef PACKET_DEFRAMER_CHECKSUM15_MACROS_SVH
`define PACKET_DEFRAMER_CHECKSUM15_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define PDC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define PDC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pdc_pkg.sv =====
package pdc_pkg;

  // Framing bytes
  localparam logic [7:0] START_FIRST  = 8'hA0;
  localparam logic [7:0] START_SECOND = 8'hA2;
  localparam logic [7:0] END_FIRST    = 8'hB0;
  localparam logic [7:0] END_SECOND   = 8'hB3;

  // Checksum is kept modulo 2^15
  localparam int unsigned SUM_W = 15;

  // Reset value of the max length register
  localparam logic [15:0] MAX_LENGTH_RESET = 16'd2048;

  // Result kinds
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Status codes
  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_BAD_START    = 3'd1,
    ST_BAD_CHECKSUM = 3'd2,
    ST_BAD_END      = 3'd3,
    ST_BAD_LENGTH   = 3'd4
  } status_t;

  // One result request
  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [7:0]  packet_type;
    logic [15:0] packet_length;
    status_t     status;
  } result_t;

  // Buffer state seen by the input stage and the checks
  typedef struct packed {
    logic       full;
    logic [1:0] count;
  } buf_status_t;

endpackage

// ===== rtl/packet_deframer_checksum15.sv =====
// Channel   | Valid / stall       | Payload
// ----------+---------------------+----------------------------------------------
// input     | in_valid / in_stall | in_rx_byte
// result    | out_valid/out_stall | out_kind, out_data_byte, out_packet_type,
//           |                     | out_packet_length, out_status
// config    | cfg_wr_en           | cfg_wr_data (max_length)
//
// One byte per cycle while the result buffer has room; a byte's result passes the
// input register, then the state step that writes it into the result buffer.
// Synchronous active-low reset: hunting, max_length = 2048, buffer empty.
// A two-entry result buffer lets input continue while a result waits; in_stall
// rises only when a byte is held and both entries are full.
`include "packet_deframer_checksum15_macros.svh"

module packet_deframer_checksum15 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [7:0]  out_data_byte,
  output logic [7:0]  out_packet_type,
  output logic [15:0] out_packet_length,
  output logic [2:0]  out_status,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  logic                 stage_valid;
  logic [7:0]           stage_byte;
  logic                 advance;
  logic                 push;
  pdc_pkg::result_t     core_result;
  pdc_pkg::result_t     out_data;
  pdc_pkg::buf_status_t buf_status;
  logic                 data_clear;

  // Held byte moves on when the buffer has room
  assign advance = stage_valid & ~buf_status.full;

  pdc_in_stage u_in_stage (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_rx_byte  (in_rx_byte),
    .in_stall    (in_stall),
    .hold        (buf_status.full),
    .stage_valid (stage_valid),
    .stage_byte  (stage_byte)
  );

  pdc_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .advance     (advance),
    .rx_byte     (stage_byte),
    .push        (push),
    .result      (core_result)
  );

  pdc_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (core_result),
    .buf_status (buf_status),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  assign out_kind          = out_data.kind;
  assign out_data_byte     = out_data.data_byte;
  assign out_packet_type   = out_data.packet_type;
  assign out_packet_length = out_data.packet_length;
  assign out_status        = out_data.status;

  // Status and length fields stay clear on a data request
  assign data_clear = (out_status == pdc_pkg::ST_OK) && (out_packet_length == 16'd0);

  // Checks
  `PDC_ASSERT_NOW(a_no_push_when_full, push, !buf_status.full, "push into full buffer")
  `PDC_ASSERT_NOW(a_stall_held, in_stall, stage_valid && buf_status.full, "idle stall")
  `PDC_ASSERT_NOW(a_data_item_clean, out_valid && !out_kind, data_clear, "bad data item")
  `PDC_ASSERT_NEXT(a_count_bounded, 1'b1, buf_status.count != 2'd3, "buffer count overflow")

endmodule

// ===== rtl/pdc_in_stage.sv =====
module pdc_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_rx_byte,
  output logic       in_stall,
  input  logic       hold,
  output logic       stage_valid,
  output logic [7:0] stage_byte
);

  logic       valid_r;
  logic [7:0] byte_r;

  // Stall only while a held byte cannot move on
  assign in_stall    = valid_r & hold;
  assign stage_valid = valid_r;
  assign stage_byte  = byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  // Payload capture, no reset needed
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      byte_r <= in_rx_byte;
    end
  end

endmodule

// ===== rtl/pdc_core.sv =====
module pdc_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [15:0]      cfg_wr_data,
  input  logic             advance,
  input  logic [7:0]       rx_byte,
  output logic             push,
  output pdc_pkg::result_t result
);

  typedef enum logic [3:0] {
    PH_HUNT   = 4'd0,
    PH_START2 = 4'd1,
    PH_LEN_LO = 4'd2,
    PH_LEN_HI = 4'd3,
    PH_TYPE   = 4'd4,
    PH_DATA   = 4'd5,
    PH_CK_LO  = 4'd6,
    PH_CK_HI  = 4'd7,
    PH_END1   = 4'd8,
    PH_END2   = 4'd9
  } phase_t;

  phase_t                       phase_r, phase_nxt;
  logic [15:0]                  max_length_r;
  logic [7:0]                   length_low_r, length_low_nxt;
  logic [15:0]                  length_value_r, length_value_nxt;
  logic [15:0]                  bytes_left_r, bytes_left_nxt;
  logic [pdc_pkg::SUM_W-1:0]    running_sum_r, running_sum_nxt;
  logic [7:0]                   type_value_r, type_value_nxt;
  logic [7:0]                   checksum_low_r, checksum_low_nxt;
  logic [15:0]                  rx_length;
  logic [15:0]                  rx_checksum;
  logic                         emit;
  pdc_pkg::result_t             res;

  assign rx_length   = {rx_byte, length_low_r};
  assign rx_checksum = {rx_byte, checksum_low_r};

  // Next state and result for the byte at the stage
  always_comb begin
    phase_nxt        = phase_r;
    length_low_nxt   = length_low_r;
    length_value_nxt = length_value_r;
    bytes_left_nxt   = bytes_left_r;
    running_sum_nxt  = running_sum_r;
    type_value_nxt   = type_value_r;
    checksum_low_nxt = checksum_low_r;
    emit             = 1'b0;
    res              = '0;
    case (phase_r)
      PH_START2: begin
        if (rx_byte != pdc_pkg::START_SECOND) begin
          emit       = 1'b1;
          res.kind   = pdc_pkg::KIND_STATUS;
          res.status = pdc_pkg::ST_BAD_START;
          phase_nxt  = PH_HUNT;
        end else begin
          phase_nxt = PH_LEN_LO;
        end
      end
      PH_LEN_LO: begin
        length_low_nxt = rx_byte;
        phase_nxt      = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        length_value_nxt = rx_length;
        if (rx_length == 16'd0 || rx_length > max_length_r) begin
          emit              = 1'b1;
          res.kind          = pdc_pkg::KIND_STATUS;
          res.packet_length = rx_length;
          res.status        = pdc_pkg::ST_BAD_LENGTH;
          phase_nxt         = PH_HUNT;
        end else begin
          bytes_left_nxt = rx_length;
          phase_nxt      = PH_TYPE;
        end
      end
      PH_TYPE: begin
        type_value_nxt  = rx_byte;
        running_sum_nxt = {7'd0, rx_byte};
        bytes_left_nxt  = bytes_left_r - 16'd1;
        phase_nxt       = (bytes_left_nxt == 16'd0) ? PH_CK_LO : PH_DATA;
      end
      PH_DATA: begin
        running_sum_nxt = running_sum_r + {7'd0, rx_byte};
        bytes_left_nxt  = bytes_left_r - 16'd1;
        if (bytes_left_nxt == 16'd0) begin
          phase_nxt = PH_CK_LO;
        end
        emit          = 1'b1;
        res.kind      = pdc_pkg::KIND_DATA;
        res.data_byte = rx_byte;
      end
      PH_CK_LO: begin
        checksum_low_nxt = rx_byte;
        phase_nxt        = PH_CK_HI;
      end
      PH_CK_HI: begin
        // bit 15 set never matches the 15-bit sum
        if (rx_checksum != {1'b0, running_sum_r}) begin
          emit              = 1'b1;
          res.kind          = pdc_pkg::KIND_STATUS;
          res.packet_type   = type_value_r;
          res.packet_length = length_value_r;
          res.status        = pdc_pkg::ST_BAD_CHECKSUM;
          phase_nxt         = PH_HUNT;
        end else begin
          phase_nxt = PH_END1;
        end
      end
      PH_END1: begin
        if (rx_byte != pdc_pkg::END_FIRST) begin
          emit              = 1'b1;
          res.kind          = pdc_pkg::KIND_STATUS;
          res.packet_type   = type_value_r;
          res.packet_length = length_value_r;
          res.status        = pdc_pkg::ST_BAD_END;
          phase_nxt         = PH_HUNT;
        end else begin
          phase_nxt = PH_END2;
        end
      end
      PH_END2: begin
        emit              = 1'b1;
        res.kind          = pdc_pkg::KIND_STATUS;
        res.packet_type   = type_value_r;
        res.packet_length = length_value_r;
        res.status        = (rx_byte != pdc_pkg::END_SECOND) ? pdc_pkg::ST_BAD_END
                                                             : pdc_pkg::ST_OK;
        phase_nxt         = PH_HUNT;
      end
      default: begin
        // hunting, also any unused phase code
        phase_nxt = (rx_byte == pdc_pkg::START_FIRST) ? PH_START2 : PH_HUNT;
      end
    endcase
  end

  assign push   = advance & emit;
  assign result = res;

  // State and config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HUNT;
      max_length_r <= pdc_pkg::MAX_LENGTH_RESET;
    end else begin
      if (cfg_wr_en) begin
        max_length_r <= cfg_wr_data;
      end
      if (advance) begin
        phase_r <= phase_nxt;
      end
    end
  end

  // Datapath state, always written before it is read
  always_ff @(posedge clk) begin
    if (advance) begin
      length_low_r   <= length_low_nxt;
      length_value_r <= length_value_nxt;
      bytes_left_r   <= bytes_left_nxt;
      running_sum_r  <= running_sum_nxt;
      type_value_r   <= type_value_nxt;
      checksum_low_r <= checksum_low_nxt;
    end
  end

endmodule

// ===== rtl/pdc_out_buf.sv =====
module pdc_out_buf (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  pdc_pkg::result_t       push_data,
  output pdc_pkg::buf_status_t   buf_status,
  output logic                   out_valid,
  input  logic                   out_stall,
  output pdc_pkg::result_t       out_data
);

  // Two-entry result buffer: entries used in turn by the write and read pointers
  pdc_pkg::result_t entry0_r, entry1_r;
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       count_r;
  logic             pop;

  assign out_valid       = (count_r != 2'd0);
  assign pop             = out_valid & ~out_stall;
  assign out_data        = rd_ptr_r ? entry1_r : entry0_r;
  assign buf_status.full = (count_r == 2'd2);
  assign buf_status.count = count_r;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push && !wr_ptr_r) begin
      entry0_r <= push_data;
    end
    if (push && wr_ptr_r) begin
      entry1_r <= push_data;
    end
  end

endmodule

// ===== tb/tb_packet_deframer_checksum15.sv =====
module tb_packet_deframer_checksum15;
  timeunit 1ns;
  timeprecision 1ps;

  // Deframer phases as tracked by the predictor
  typedef enum logic [3:0] {
    PH_HUNT, PH_SYNC2, PH_LEN_LO, PH_LEN_HI, PH_TYPE,
    PH_DATA, PH_SUM_LO, PH_SUM_HI, PH_END1, PH_END2
  } rx_phase_t;

  // Ways a generated packet can be broken
  typedef enum int {
    FR_GOOD, FR_BAD_SYNC, FR_BAD_LENGTH, FR_BAD_SUM, FR_BAD_END1, FR_BAD_END2
  } frame_fault_t;

  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned HOLD_CYCLES   = 80;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_kind;
  logic [7:0]  out_data_byte;
  logic [7:0]  out_packet_type;
  logic [15:0] out_packet_length;
  logic [2:0]  out_status;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = 16'h0000;

  packet_deframer_checksum15 dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_data_byte     (out_data_byte),
    .out_packet_type   (out_packet_type),
    .out_packet_length (out_packet_length),
    .out_status        (out_status),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  always #4 clk = ~clk;

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Overall time limit
  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Byte stream waiting to be sent, and results still owed by the block
  logic [7:0]        pending_bytes[$];
  pdc_pkg::result_t  due_results[$];
  int unsigned       stim_count = 0;
  int unsigned       mismatch_count = 0;

  // Predictor state
  rx_phase_t   rx_phase = PH_HUNT;
  logic [15:0] max_len_cfg = pdc_pkg::MAX_LENGTH_RESET;
  logic [7:0]  len_low = 8'h00;
  logic [15:0] frame_len = 16'h0000;
  logic [15:0] remaining = 16'h0000;
  logic [14:0] frame_sum = 15'h0000;
  logic [7:0]  frame_type = 8'h00;
  logic [7:0]  sum_low = 8'h00;

  // Traffic shaping
  logic        sender_steady = 1'b0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_served = 0;
  int unsigned hold_left = 0;
  logic [15:0] stall_pattern = 16'h0000;
  int unsigned pattern_age = 0;

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 50) begin
      $display("[%0t] ERROR: %s", $time, what);
    end
  endtask

  // Status request closes the packet and sends the block back to hunting
  function automatic void close_packet(input logic [7:0] typ, input logic [15:0] len,
                                       input pdc_pkg::status_t st);
    pdc_pkg::result_t r;
    r = '0;
    r.kind = pdc_pkg::KIND_STATUS;
    r.packet_type = typ;
    r.packet_length = len;
    r.status = st;
    due_results.push_back(r);
    rx_phase = PH_HUNT;
  endfunction

  // One received byte through the deframer state machine
  function automatic void deframe_byte(input logic [7:0] b);
    pdc_pkg::result_t r;
    case (rx_phase)
      PH_SYNC2: begin
        if (b != pdc_pkg::START_SECOND) close_packet(8'h00, 16'h0000, pdc_pkg::ST_BAD_START);
        else rx_phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len_low = b;
        rx_phase = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        frame_len = {b, len_low};
        if (frame_len == 16'h0000 || frame_len > max_len_cfg) begin
          close_packet(8'h00, frame_len, pdc_pkg::ST_BAD_LENGTH);
        end else begin
          remaining = frame_len;
          rx_phase = PH_TYPE;
        end
      end
      PH_TYPE: begin
        frame_type = b;
        frame_sum = 15'(b);
        remaining = remaining - 16'd1;
        rx_phase = (remaining == 16'h0000) ? PH_SUM_LO : PH_DATA;
      end
      PH_DATA: begin
        frame_sum = frame_sum + 15'(b);
        remaining = remaining - 16'd1;
        if (remaining == 16'h0000) rx_phase = PH_SUM_LO;
        r = '0;
        r.kind = pdc_pkg::KIND_DATA;
        r.data_byte = b;
        r.status = pdc_pkg::ST_OK;
        due_results.push_back(r);
      end
      PH_SUM_LO: begin
        sum_low = b;
        rx_phase = PH_SUM_HI;
      end
      PH_SUM_HI: begin
        // bit 15 of the received word can never match the 15-bit sum
        if ({b, sum_low} != {1'b0, frame_sum}) begin
          close_packet(frame_type, frame_len, pdc_pkg::ST_BAD_CHECKSUM);
        end else begin
          rx_phase = PH_END1;
        end
      end
      PH_END1: begin
        if (b != pdc_pkg::END_FIRST) close_packet(frame_type, frame_len, pdc_pkg::ST_BAD_END);
        else rx_phase = PH_END2;
      end
      PH_END2: begin
        if (b != pdc_pkg::END_SECOND) close_packet(frame_type, frame_len, pdc_pkg::ST_BAD_END);
        else close_packet(frame_type, frame_len, pdc_pkg::ST_OK);
      end
      default: rx_phase = (b == pdc_pkg::START_FIRST) ? PH_SYNC2 : PH_HUNT;
    endcase
  endfunction

  // Driver: offers queued bytes in bursts, holds the request while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_rx_byte <= 8'h00;
    end else begin
      if (in_valid && !in_stall) begin
        deframe_byte(in_rx_byte);
        void'(pending_bytes.pop_front());
      end
      if (in_valid && in_stall) begin
        // stalled: keep valid and payload as they are
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_bytes.size() == 0) begin
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        in_rx_byte <= pending_bytes[0];
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          if (sender_steady || $urandom_range(0, 2) == 0) gap_left = 0;
          else gap_left = $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end
    end
  end

  task automatic check_result();
    pdc_pkg::result_t want;
    if (due_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result kind=%0d data=%02h type=%02h len=%0d st=%0d",
                                out_kind, out_data_byte, out_packet_type,
                                out_packet_length, out_status));
      return;
    end
    want = due_results.pop_front();
    if (out_kind !== want.kind)
      report_mismatch($sformatf("kind %0d, expected %0d", out_kind, want.kind));
    if (out_data_byte !== want.data_byte)
      report_mismatch($sformatf("data_byte %02h, expected %02h", out_data_byte,
                                want.data_byte));
    if (out_packet_type !== want.packet_type)
      report_mismatch($sformatf("packet_type %02h, expected %02h", out_packet_type,
                                want.packet_type));
    if (out_packet_length !== want.packet_length)
      report_mismatch($sformatf("packet_length %0d, expected %0d", out_packet_length,
                                want.packet_length));
    if (out_status !== want.status)
      report_mismatch($sformatf("status %0d, expected %0d", out_status, want.status));
  endtask

  // Monitor: checks accepted results and drives the receiver's stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_result();
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (holds_served < hold_requests) begin
        // long hold-off so the block backs up into its input
        holds_served++;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        if (pattern_age == 0) begin
          case ($urandom_range(0, 3))
            0: stall_pattern = 16'h0000;
            1: stall_pattern = 16'($urandom);
            2: stall_pattern = 16'($urandom & $urandom);
            default: stall_pattern = 16'($urandom | $urandom);
          endcase
          pattern_age = 16;
        end
        pattern_age--;
        out_stall <= stall_pattern[0];
        stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
      end
    end
  end

  task automatic push_rx(input logic [7:0] b);
    pending_bytes.push_back(b);
    stim_count++;
  endtask

  function automatic logic [7:0] other_than(input logic [7:0] x);
    logic [7:0] d;
    d = 8'($urandom);
    if (d == x) d = ~x;
    return d;
  endfunction

  // Queue one packet; heavy fills the data with large bytes to wrap the sum
  task automatic queue_packet(input int unsigned len, input frame_fault_t fault,
                              input bit heavy);
    logic [7:0]  d;
    logic [14:0] sum;
    logic [15:0] ck;
    push_rx(pdc_pkg::START_FIRST);
    if (fault == FR_BAD_SYNC) begin
      push_rx(other_than(pdc_pkg::START_SECOND));
      return;
    end
    push_rx(pdc_pkg::START_SECOND);
    push_rx(len[7:0]);
    push_rx(len[15:8]);
    if (fault == FR_BAD_LENGTH) return;
    d = 8'($urandom);
    sum = 15'(d);
    push_rx(d);
    for (int unsigned i = 1; i < len; i++) begin
      d = heavy ? 8'($urandom_range(200, 255)) : 8'($urandom);
      sum = sum + 15'(d);
      push_rx(d);
    end
    ck = {1'b0, sum};
    if (fault == FR_BAD_SUM) begin
      if ($urandom_range(0, 1) == 0) ck[15] = 1'b1;
      else ck = ck ^ (16'h0001 << $urandom_range(0, 14));
    end
    push_rx(ck[7:0]);
    push_rx(ck[15:8]);
    if (fault == FR_BAD_SUM) return;
    if (fault == FR_BAD_END1) begin
      push_rx(other_than(pdc_pkg::END_FIRST));
      return;
    end
    push_rx(pdc_pkg::END_FIRST);
    push_rx((fault == FR_BAD_END2) ? other_than(pdc_pkg::END_SECOND) : pdc_pkg::END_SECOND);
  endtask

  // Mostly short packets, now and then one of the largest allowed here
  function automatic int unsigned pick_length();
    int unsigned top;
    top = (max_len_cfg < 48) ? max_len_cfg : 48;
    case ($urandom_range(0, 19))
      0: return top;
      1, 2: return $urandom_range(1, top);
      default: return $urandom_range(1, (top < 12) ? top : 12);
    endcase
  endfunction

  function automatic int unsigned pick_bad_length();
    if (max_len_cfg == 16'hFFFF || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(int'(max_len_cfg) + 1, 65535);
  endfunction

  task automatic random_traffic(input int unsigned n_bytes);
    int unsigned goal;
    int unsigned pick;
    goal = stim_count + n_bytes;
    while (stim_count < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) repeat ($urandom_range(1, 4)) push_rx(8'($urandom));
      else if (pick < 60) queue_packet(pick_length(), FR_GOOD, 0);
      else if (pick < 67) queue_packet(0, FR_BAD_SYNC, 0);
      else if (pick < 75) queue_packet(pick_bad_length(), FR_BAD_LENGTH, 0);
      else if (pick < 85) queue_packet(pick_length(), FR_BAD_SUM, 0);
      else if (pick < 92) queue_packet(pick_length(), FR_BAD_END1, 0);
      else queue_packet(pick_length(), FR_BAD_END2, 0);
    end
  endtask

  // Sender pauses until every owed result is back and the pipe is quiet
  task automatic drain(input int unsigned settle);
    while (pending_bytes.size() != 0 || due_results.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_max_length(input logic [15:0] v);
    drain(SETTLE_CYCLES);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    max_len_cfg = v;
  endtask

  // Stimulus
  initial begin
    wait (rst_n === 1'b1);
    @(posedge clk);

    // directed: dropped bytes, bad start, zero and oversized length, type only
    push_rx(8'h00);
    push_rx(8'hFF);
    queue_packet(0, FR_BAD_SYNC, 0);
    queue_packet(0, FR_BAD_LENGTH, 0);
    queue_packet(16'hFFFF, FR_BAD_LENGTH, 0);
    queue_packet(1, FR_GOOD, 0);
    random_traffic(150);

    // smallest limit: only type-only packets get through
    write_max_length(16'd1);
    queue_packet(1, FR_GOOD, 0);
    queue_packet(2, FR_BAD_LENGTH, 0);
    random_traffic(150);

    // largest limit, plus a long packet held back at the receiver
    write_max_length(16'hFFFF);
    random_traffic(150);
    drain(SETTLE_CYCLES);
    sender_steady = 1'b1;
    queue_packet(180, FR_GOOD, 1);
    hold_requests++;
    drain(SETTLE_CYCLES);
    sender_steady = 1'b0;

    write_max_length(16'($urandom_range(2, 48)));
    random_traffic(130);

    write_max_length(16'($urandom_range(100, 4000)));
    random_traffic(130);

    write_max_length(pdc_pkg::MAX_LENGTH_RESET);
    random_traffic(70);

    drain(10);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== packet_deframer_checksum15.f =====
+incdir+rtl
rtl/pdc_pkg.sv
rtl/pdc_in_stage.sv
rtl/pdc_core.sv
rtl/pdc_out_buf.sv
rtl/packet_deframer_checksum15.sv
tb/tb_packet_deframer_checksum15.sv
